// ===== rtl/core/abd_pkg.sv =====
// Package for the anchor box decode and argmax block.
// Holds the work-item types, channel codes, fixed-point constants and anchor tables.
// No dependencies.
package abd_pkg;

	localparam int NUM_CLASSES = 80;
	localparam int NUM_ANCHORS = 3;
	localparam int GRID_MAX    = 64;
	localparam int FRAC_BITS   = 16;

	localparam int LAST_CH = 4 + NUM_CLASSES;

	localparam logic [16:0] ONE_FX = 17'(1 << FRAC_BITS);

	localparam logic [6:0] CH_X    = 7'd0;
	localparam logic [6:0] CH_Y    = 7'd1;
	localparam logic [6:0] CH_W    = 7'd2;
	localparam logic [6:0] CH_H    = 7'd3;
	localparam logic [6:0] CH_CONF = 7'd4;
	localparam logic [6:0] CH_CLS0 = 7'd5;

	localparam logic signed [14:0] COORD_MIN = -15'sd1024;
	localparam logic signed [14:0] COORD_MAX = 15'sd2047;

	// anchor width and height, indexed [scale][anchor]
	localparam logic [8:0] ANCHOR_W [0:2][0:2] = '{
		'{9'd10,  9'd16,  9'd33},
		'{9'd30,  9'd62,  9'd59},
		'{9'd116, 9'd156, 9'd373}
	};
	localparam logic [8:0] ANCHOR_H [0:2][0:2] = '{
		'{9'd13,  9'd30,  9'd23},
		'{9'd61,  9'd45,  9'd119},
		'{9'd90,  9'd198, 9'd326}
	};

	typedef struct packed {
		logic [16:0] raw_x;
		logic [16:0] raw_y;
		logic [16:0] raw_w;
		logic [16:0] raw_h;
		logic [16:0] objectness;
		logic [16:0] best_prob;
		logic [6:0]  best_label;
		logic [5:0]  cell_col;
		logic [5:0]  cell_row;
		logic [1:0]  anchor_sel;
		logic [1:0]  scale_sel;
	} job_t;

	typedef struct packed {
		logic signed [11:0] box_xmin;
		logic signed [11:0] box_ymin;
		logic signed [11:0] box_xmax;
		logic signed [11:0] box_ymax;
		logic [6:0]         class_label;
		logic [16:0]        box_score;
	} result_t;

endpackage

// ===== rtl/core/abd_fifo.sv =====
// Small synchronous queue with push/full and pop/empty sides.
// Used between front and back and on the result side; no package dependency.
module abd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== rtl/core/abd_front.sv =====
// Front end: captures channel words, runs the class argmax and queues box jobs.
// Depends on abd_pkg.
module abd_front
	import abd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [16:0] act_value,
	input  logic [6:0]  channel,
	input  logic [5:0]  cell_col,
	input  logic [5:0]  cell_row,
	input  logic [1:0]  anchor_sel,
	input  logic [1:0]  scale_sel,
	input  logic [16:0] conf_threshold,
	output logic        job_push,
	output job_t        job
);

	logic [16:0] raw_x_q, raw_y_q, raw_w_q, raw_h_q, obj_q, best_prob_q;
	logic [6:0]  best_label_q;
	logic [16:0] v;
	logic        is_class, is_last, take;
	logic [16:0] nxt_prob;
	logic [6:0]  nxt_label;
	logic [1:0]  anc_c, scl_c;
	logic [5:0]  col_c, row_c;

	always_comb begin
		v         = (act_value > ONE_FX) ? ONE_FX : act_value;
		is_class  = (channel >= CH_CLS0) && ({1'b0, channel} <= 8'(LAST_CH));
		is_last   = ({1'b0, channel} == 8'(LAST_CH));
		take      = is_class && (v > best_prob_q);
		nxt_prob  = take ? v : best_prob_q;
		nxt_label = take ? 7'(channel - CH_CLS0) : best_label_q;

		// clamp the tags of the last class word
		scl_c = (scale_sel > 2'd2) ? 2'd2 : scale_sel;
		anc_c = anchor_sel;
		if (int'(anc_c) > NUM_ANCHORS - 1) begin
			anc_c = 2'(NUM_ANCHORS - 1);
		end
		if (anc_c > 2'd2) begin
			anc_c = 2'd2;
		end
		col_c = (int'(cell_col) > GRID_MAX - 1) ? 6'(GRID_MAX - 1) : cell_col;
		row_c = (int'(cell_row) > GRID_MAX - 1) ? 6'(GRID_MAX - 1) : cell_row;

		job_push = accept && is_last && (obj_q > conf_threshold);

		job.raw_x      = raw_x_q;
		job.raw_y      = raw_y_q;
		job.raw_w      = raw_w_q;
		job.raw_h      = raw_h_q;
		job.objectness = obj_q;
		job.best_prob  = nxt_prob;
		job.best_label = nxt_label;
		job.cell_col   = col_c;
		job.cell_row   = row_c;
		job.anchor_sel = anc_c;
		job.scale_sel  = scl_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_x_q      <= '0;
			raw_y_q      <= '0;
			raw_w_q      <= '0;
			raw_h_q      <= '0;
			obj_q        <= '0;
			best_prob_q  <= '0;
			best_label_q <= '0;
		end else if (accept) begin
			case (channel)
				CH_X: begin
					raw_x_q      <= v;
					best_prob_q  <= '0;
					best_label_q <= '0;
				end
				CH_Y:    raw_y_q <= v;
				CH_W:    raw_w_q <= v;
				CH_H:    raw_h_q <= v;
				CH_CONF: obj_q   <= v;
				default: begin
					// restart the argmax once the cell is closed
					if (is_last) begin
						best_prob_q  <= '0;
						best_label_q <= '0;
					end else if (is_class) begin
						best_prob_q  <= nxt_prob;
						best_label_q <= nxt_label;
					end
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/abd_back.sv =====
// Back end: turns one box job into corner coordinates and score in three stages.
// Depends on abd_pkg.
module abd_back
	import abd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  job_t    job,
	input  logic    job_empty,
	output logic    job_pop,
	input  logic    res_full,
	output logic    res_push,
	output result_t res
);

	localparam int Q2 = 2 * FRAC_BITS;
	localparam logic signed [24:0] HALF_FX = 25'(1 << (FRAC_BITS - 1));

	logic                v_s1, v_s2, v_s3;
	logic signed [29:0]  cx_s1, cy_s1, cx_s2, cy_s2;
	logic [33:0]         sqw_s1, sqh_s1, score_s1;
	logic [8:0]          aw_s1, ah_s1;
	logic [6:0]          label_s1, label_s2, label_s3;
	logic [43:0]         hw_s2, hh_s2;
	logic [16:0]         score_s2, score_s3;
	logic signed [46:0]  xlo_s3, ylo_s3, xhi_s3, yhi_s3;
	logic signed [24:0]  tx, ty;
	logic [2:0]          shift;
	logic signed [46:0]  cqx, cqy, hwx, hhx;

	// truncate a Q.32 value toward zero and saturate to pixel range
	function automatic logic signed [11:0] to_pixel(input logic signed [46:0] s);
		logic signed [14:0] q;
		q = 15'(s >>> Q2);
		if (s[46] && (s[Q2-1:0] != '0)) begin
			q = q + 15'sd1;
		end
		if (q < COORD_MIN) begin
			q = COORD_MIN;
		end else if (q > COORD_MAX) begin
			q = COORD_MAX;
		end
		return 12'(q);
	endfunction

	// one job in flight; the result queue cannot fill behind it
	assign job_pop  = !job_empty && !res_full && !(v_s1 || v_s2 || v_s3);
	assign res_push = v_s3;

	always_comb begin
		tx    = $signed(25'(job.raw_x) << 1) + $signed(25'(job.cell_col) << FRAC_BITS) - HALF_FX;
		ty    = $signed(25'(job.raw_y) << 1) + $signed(25'(job.cell_row) << FRAC_BITS) - HALF_FX;
		shift = 3'd3 + 3'(job.scale_sel);
		cqx   = {cx_s2[29], cx_s2, 16'b0};
		cqy   = {cy_s2[29], cy_s2, 16'b0};
		hwx   = {3'b0, hw_s2};
		hhx   = {3'b0, hh_s2};

		res.box_xmin    = to_pixel(xlo_s3);
		res.box_ymin    = to_pixel(ylo_s3);
		res.box_xmax    = to_pixel(xhi_s3);
		res.box_ymax    = to_pixel(yhi_s3);
		res.class_label = label_s3;
		res.box_score   = score_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= job_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			cx_s1    <= 30'(tx) <<< shift;
			cy_s1    <= 30'(ty) <<< shift;
			sqw_s1   <= 34'(job.raw_w) * 34'(job.raw_w);
			sqh_s1   <= 34'(job.raw_h) * 34'(job.raw_h);
			score_s1 <= 34'(job.objectness) * 34'(job.best_prob);
			aw_s1    <= ANCHOR_W[job.scale_sel][job.anchor_sel];
			ah_s1    <= ANCHOR_H[job.scale_sel][job.anchor_sel];
			label_s1 <= job.best_label;
		end
		if (v_s1) begin
			cx_s2    <= cx_s1;
			cy_s2    <= cy_s1;
			// half size = 2 * v^2 * anchor
			hw_s2    <= {43'(sqw_s1) * 43'(aw_s1), 1'b0};
			hh_s2    <= {43'(sqh_s1) * 43'(ah_s1), 1'b0};
			score_s2 <= 17'(score_s1 >> FRAC_BITS);
			label_s2 <= label_s1;
		end
		if (v_s2) begin
			xlo_s3   <= cqx - hwx;
			xhi_s3   <= cqx + hwx;
			ylo_s3   <= cqy - hhx;
			yhi_s3   <= cqy + hhx;
			score_s3 <= score_s2;
			label_s3 <= label_s2;
		end
	end

endmodule

// ===== rtl/core/anchor_box_decode_argmax_top.sv =====
// Top level of the anchor box decode and argmax block.
// Depends on abd_pkg, abd_fifo, abd_front and abd_back.
//
// Usage:
//  - Input side is a queue: drive act_value, channel and the cell tags, raise push;
//    the word is taken on a clock edge with push high and full low. Send the
//    85 channel words of one cell/anchor in order 0..84, one per cycle if desired.
//  - Result side is a queue: while empty is low the oldest box is on the box_*,
//    class_label and box_score ports; pop with empty low takes it.
//  - cfg_valid/cfg_data write the confidence threshold; cfg_ready is always high.
//    Write it only while the block is idle.
//  - Throughput: one input word per cycle while full is low. The front end stores
//    channels and runs the argmax at one word per cycle; box jobs queue behind it.
//  - The box of a passing cell, once its last class word is taken, passes the job
//    queue, three back-end stages and result queue. The back end holds one job at
//    a time and takes a new one only after its box has left the third stage.
//  - A stalled receiver fills the result queue, then the job queue; full rises only
//    once the job queue holds QUEUE_DEPTH boxes.
//  - Reset clears channel state and both queues and loads threshold 0.25 (16384).
module anchor_box_decode_argmax_top
	import abd_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [16:0]        act_value,
	input  logic [6:0]         channel,
	input  logic [5:0]         cell_col,
	input  logic [5:0]         cell_row,
	input  logic [1:0]         anchor_sel,
	input  logic [1:0]         scale_sel,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [16:0]        cfg_data,
	output logic               empty,
	input  logic               pop,
	output logic signed [11:0] box_xmin,
	output logic signed [11:0] box_ymin,
	output logic signed [11:0] box_xmax,
	output logic signed [11:0] box_ymax,
	output logic [6:0]         class_label,
	output logic [16:0]        box_score
);

	logic [16:0] conf_threshold_q;
	logic        accept;
	logic        job_push, job_full, job_empty, job_pop;
	job_t        job_in, job_out;
	logic        res_push, res_full;
	result_t     res_in, res_out;

	assign cfg_ready = 1'b1;
	// accept a word only while the job queue has room
	assign full      = job_full;
	assign accept    = push && !job_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conf_threshold_q <= 17'd16384;
		end else if (cfg_valid && cfg_ready) begin
			conf_threshold_q <= cfg_data;
		end
	end

	abd_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.act_value      (act_value),
		.channel        (channel),
		.cell_col       (cell_col),
		.cell_row       (cell_row),
		.anchor_sel     (anchor_sel),
		.scale_sel      (scale_sel),
		.conf_threshold (conf_threshold_q),
		.job_push       (job_push),
		.job            (job_in)
	);

	abd_fifo #(
		.WIDTH ($bits(job_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (job_in),
		.full   (job_full),
		.pop    (job_pop),
		.rdata  (job_out),
		.empty  (job_empty)
	);

	abd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job_out),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	abd_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign box_xmin    = res_out.box_xmin;
	assign box_ymin    = res_out.box_ymin;
	assign box_xmax    = res_out.box_xmax;
	assign box_ymax    = res_out.box_ymax;
	assign class_label = res_out.class_label;
	assign box_score   = res_out.box_score;

	// a job is never dropped at a full queue
	a_job_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !job_full)
		else $error("job pushed into full queue");

	// a box is never dropped at a full result queue
	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into full queue");

	// every box leaves the back end once its job has passed v_s1, v_s2 and v_s3
	a_res_from_job: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> $past(job_pop, 3))
		else $error("result without matching job");

	// the back end holds one job at a time
	a_single_flight: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> !job_pop)
		else $error("back end took two jobs in a row");

endmodule
